FILE: rtl/gbpf_pkg.sv
// package for the grid breadth-first path finder: types, sizes and helpers
`default_nettype none

package gbpf_pkg;

    // grid dimensions
    localparam int GRID_ROWS   = 8;
    localparam int GRID_COLS   = 8;
    localparam int COORD_LIMIT = 8;
    localparam int CELLS       = GRID_ROWS * GRID_COLS;
    localparam int CELL_W      = $clog2(CELLS);
    localparam int PTR_W       = CELL_W + 1;
    localparam int COORD_W     = 3;
    localparam int DIM_W       = 4;

    // usable dimension caps
    localparam int ROWS_CAP = (GRID_ROWS < COORD_LIMIT) ? GRID_ROWS : COORD_LIMIT;
    localparam int COLS_CAP = (GRID_COLS < COORD_LIMIT) ? GRID_COLS : COORD_LIMIT;

    // configuration register indexes
    localparam logic REG_ROWS_IN_USE = 1'b0;
    localparam logic REG_COLS_IN_USE = 1'b1;

    // request types
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [DIM_W-1:0]   dim_t;
    typedef logic [CELL_W-1:0]  cell_idx_t;
    typedef logic [PTR_W-1:0]   ptr_t;

    // move that discovered a cell
    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    typedef struct packed {
        coord_t row;
        coord_t col;
    } pos_t;

    typedef struct packed {
        logic   req_type;
        coord_t cell_row;
        coord_t cell_col;
        logic   cell_blocked;
        coord_t src_row;
        coord_t src_col;
        coord_t dst_row;
        coord_t dst_col;
    } gbpf_in_t;

    typedef struct packed {
        logic   found;
        coord_t path_row;
        coord_t path_col;
        logic   last;
    } gbpf_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_CHECK,
        ST_EXPAND,
        ST_EMIT,
        ST_TRACE,
        ST_FAIL
    } gbpf_state_t;

    function automatic cell_idx_t cell_addr(input coord_t r, input coord_t c);
        int unsigned a;
        a = int'(r) * GRID_COLS + int'(c);
        return a[CELL_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/grid_bfs_path_finder_core.sv
// top level of the grid breadth-first path finder
`default_nettype none

//  channel   direction  handshake          payload
//  in        input      in_valid/in_stall  in_data   (gbpf_in_t: write or query)
//  out       output     out_valid/out_stall out_data (gbpf_out_t: path cells)
//  cfg       apb        psel/penable       rows_in_use, cols_in_use
//
//  a write item is taken in the idle state; a query walks each dequeued cell during
//  the search through one queue read, one compare and four neighbor checks on the
//  shared unit, then emits each path cell and traces back to its parent; the single
//  neighbor check unit and the one-write-port queue memory keep the search sequential
//  reset clears occupancy, the search state and the output valid flag at once
//  in_stall is high while a query is in progress; out_stall holds the output
//  register and the trace waits for it

module grid_bfs_path_finder_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire gbpf_pkg::gbpf_in_t in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output gbpf_pkg::gbpf_out_t     out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import gbpf_pkg::*;

    // control and search state
    gbpf_state_t      state_reg, state_next;
    dim_t             rows_reg, cols_reg;
    logic [CELLS-1:0] occ_reg, occ_next;
    logic [CELLS-1:0] visited_reg, visited_next;
    ptr_t             head_reg, head_next;
    ptr_t             tail_reg, tail_next;
    logic [1:0]       dir_reg, dir_next;
    cell_idx_t        cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    // payload registers
    pos_t      cur_reg, cur_next;
    pos_t      src_reg, src_next;
    pos_t      dst_reg, dst_next;
    gbpf_out_t out_data_reg, out_data_next;

    // frontier queue and parent direction memories
    pos_t       queue_mem [CELLS];
    logic [1:0] parent_mem [CELLS];
    pos_t       q_rdata_reg;
    logic [1:0] p_rdata_reg;

    logic       q_we;
    cell_idx_t  q_waddr;
    pos_t       q_wdata;
    logic       p_we;
    cell_idx_t  p_waddr;
    logic [1:0] p_wdata;

    // usable dimensions
    dim_t nr, nc;
    assign nr = (rows_reg > DIM_W'(ROWS_CAP)) ? DIM_W'(ROWS_CAP) : rows_reg;
    assign nc = (cols_reg > DIM_W'(COLS_CAP)) ? DIM_W'(COLS_CAP) : cols_reg;

    // shared neighbor check unit
    pos_t      nb_pos;
    logic      nb_ok;
    cell_idx_t nb_idx;
    logic      nb_push;

    always_comb
    begin
        nb_pos = cur_reg;
        nb_ok  = 1'b0;
        case (dir_t'(dir_reg))
            DIR_UP:
            begin
                nb_ok      = (cur_reg.row != '0);
                nb_pos.row = cur_reg.row - COORD_W'(1);
            end
            DIR_LEFT:
            begin
                nb_ok      = (cur_reg.col != '0);
                nb_pos.col = cur_reg.col - COORD_W'(1);
            end
            DIR_DOWN:
            begin
                nb_ok      = ({1'b0, cur_reg.row} + DIM_W'(1)) < nr;
                nb_pos.row = cur_reg.row + COORD_W'(1);
            end
            DIR_RIGHT:
            begin
                nb_ok      = ({1'b0, cur_reg.col} + DIM_W'(1)) < nc;
                nb_pos.col = cur_reg.col + COORD_W'(1);
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
        nb_idx  = cell_addr(nb_pos.row, nb_pos.col);
        nb_push = nb_ok && !occ_reg[nb_idx] && !visited_reg[nb_idx]
                  && (tail_reg < PTR_W'(CELLS));
    end

    // trace step: undo the move that discovered the current cell
    pos_t prev_pos;

    always_comb
    begin
        prev_pos = cur_reg;
        case (dir_t'(p_rdata_reg))
            DIR_UP:    prev_pos.row = cur_reg.row + COORD_W'(1);
            DIR_LEFT:  prev_pos.col = cur_reg.col + COORD_W'(1);
            DIR_DOWN:  prev_pos.row = cur_reg.row - COORD_W'(1);
            DIR_RIGHT: prev_pos.col = cur_reg.col - COORD_W'(1);
            default:   prev_pos = cur_reg;
        endcase
    end

    logic out_free;
    logic trace_last;
    logic range_bad;
    pos_t in_src, in_dst;

    assign out_free   = !out_valid_reg || !out_stall;
    assign trace_last = (cur_reg == src_reg) || (cnt_reg == CELL_W'(CELLS - 1));
    assign in_src     = '{row: in_data.src_row, col: in_data.src_col};
    assign in_dst     = '{row: in_data.dst_row, col: in_data.dst_col};
    assign range_bad  = ({1'b0, in_data.src_row} >= nr) || ({1'b0, in_data.src_col} >= nc)
                        || ({1'b0, in_data.dst_row} >= nr) || ({1'b0, in_data.dst_col} >= nc);

    // sequencer: next state and datapath controls
    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        visited_next   = visited_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        dir_next       = dir_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        q_we           = 1'b0;
        q_waddr        = tail_reg[CELL_W-1:0];
        q_wdata        = nb_pos;
        p_we           = 1'b0;
        p_waddr        = nb_idx;
        p_wdata        = dir_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.req_type == REQ_WRITE)
                    begin
                        // writes beyond the grid are dropped
                        if ((int'(in_data.cell_row) < GRID_ROWS)
                            && (int'(in_data.cell_col) < GRID_COLS))
                        begin
                            occ_next[cell_addr(in_data.cell_row, in_data.cell_col)] =
                                in_data.cell_blocked;
                        end
                    end
                    else if (range_bad)
                    begin
                        state_next = ST_FAIL;
                    end
                    else
                    begin
                        // start search: clear visited, seed queue with the source
                        src_next     = in_src;
                        dst_next     = in_dst;
                        visited_next = '0;
                        visited_next[cell_addr(in_src.row, in_src.col)] = 1'b1;
                        q_we         = 1'b1;
                        q_waddr      = '0;
                        q_wdata      = in_src;
                        head_next    = '0;
                        tail_next    = PTR_W'(1);
                        state_next   = ST_POP;
                    end
                end
            end

            ST_POP:
            begin
                // queue read of the head entry lands in q_rdata_reg
                if (head_reg == tail_reg)
                begin
                    state_next = ST_FAIL;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                cur_next = q_rdata_reg;
                if (q_rdata_reg == dst_reg)
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    head_next  = head_reg + PTR_W'(1);
                    dir_next   = DIR_UP;
                    state_next = ST_EXPAND;
                end
            end

            ST_EXPAND:
            begin
                // one neighbor per cycle in order up, left, down, right
                if (nb_push)
                begin
                    visited_next[nb_idx] = 1'b1;
                    p_we      = 1'b1;
                    q_we      = 1'b1;
                    tail_next = tail_reg + PTR_W'(1);
                end
                dir_next = dir_reg + 2'd1;
                if (dir_reg == DIR_RIGHT)
                begin
                    state_next = ST_POP;
                end
            end

            ST_EMIT:
            begin
                // parent of the current cell is read meanwhile
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{found: 1'b1, path_row: cur_reg.row,
                                       path_col: cur_reg.col, last: trace_last};
                    state_next     = trace_last ? ST_IDLE : ST_TRACE;
                end
            end

            ST_TRACE:
            begin
                cur_next   = prev_pos;
                cnt_next   = cnt_reg + CELL_W'(1);
                state_next = ST_EMIT;
            end

            ST_FAIL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{found: 1'b0, path_row: '0, path_col: '0, last: 1'b1};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            visited_reg   <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            dir_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            visited_reg   <= visited_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            dir_reg       <= dir_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        out_data_reg <= out_data_next;
    end

    // queue memory: one write port, registered read at the head
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[q_waddr] <= q_wdata;
        end
        q_rdata_reg <= queue_mem[head_reg[CELL_W-1:0]];
    end

    // parent direction memory: written on discovery, read at the trace cell
    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            parent_mem[p_waddr] <= p_wdata;
        end
        p_rdata_reg <= parent_mem[cell_addr(cur_reg.row, cur_reg.col)];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= DIM_W'(8);
            cols_reg <= DIM_W'(8);
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_ROWS_IN_USE)
            begin
                rows_reg <= pwdata[DIM_W-1:0];
            end
            else
            begin
                cols_reg <= pwdata[DIM_W-1:0];
            end
        end
    end

    assign prdata    = (paddr[2] == REG_COLS_IN_USE) ? {28'd0, cols_reg} : {28'd0, rows_reg};
    assign pready    = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: tb/tb_grid_bfs_path_finder_core.sv
// testbench for grid_bfs_path_finder_core: directed and random mazes checked against a bfs predictor
`timescale 1ns / 1ps

module tb;
    import gbpf_pkg::*;

    localparam int RUN_LIMIT      = 3_000_000;  // cycles before the run is declared hung
    localparam int DRAIN_CYCLES   = 16;         // lets a final cell write land
    localparam int FINAL_SETTLE   = 600;        // margin for a full 8x8 search
    localparam int HOLDOFF_CYCLES = 1500;       // long output hold-off
    localparam int MAX_REPORTS    = 60;         // mismatches printed; all are counted

    // dut signals
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    gbpf_in_t    in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    gbpf_out_t   out_data;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    // pacing of both channels
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic recv_hold      = 1'b0;
    event holdoff_kick;

    // predictor state: occupancy, configured dimensions and the search scratch
    dim_t      rows_cfg = 4'd8;
    dim_t      cols_cfg = 4'd8;
    bit        blocked_map [CELLS];
    bit        reached     [CELLS];
    dir_t      came_from   [CELLS];
    cell_idx_t frontier    [CELLS];
    int        frontier_tail;

    // path cells still owed by the block, oldest first
    gbpf_out_t expected_cells [$];

    // run statistics
    int unsigned cycle_count    = 0;
    int          mismatch_count = 0;
    int          items_accepted = 0;
    int          cell_writes    = 0;
    int          queries        = 0;
    int          results_seen   = 0;
    int          paths_found    = 0;
    int          no_path_items  = 0;
    int          longest_path   = 0;

    grid_bfs_path_finder_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hang guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d cells still pending",
                     cycle_count, expected_cells.size());
            $display("grid_bfs_path_finder_core test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // rows or columns actually searched for a register value
    function automatic int usable_dim(input dim_t value, input int cap);
        return (int'(value) > cap) ? cap : int'(value);
    endfunction

    // mark a neighbor found, remember the move that reached it and queue it
    function automatic void discover(input int r, input int c, input dir_t move);
        int idx;
        idx = r * GRID_COLS + c;
        if (blocked_map[idx] || reached[idx])
            return;
        reached[idx]            = 1'b1;
        came_from[idx]          = move;
        frontier[frontier_tail] = cell_idx_t'(idx);
        frontier_tail++;
    endfunction

    function automatic void expect_no_path();
        gbpf_out_t res;
        res       = '0;
        res.last  = 1'b1;
        no_path_items++;
        expected_cells.push_back(res);
    endfunction

    // apply one accepted item: update occupancy or queue the expected path cells
    function automatic void predict_grid_item(input gbpf_in_t it);
        int        nr, nc, src, dst, head, cur, r, c, k;
        gbpf_out_t res;

        if (it.req_type == REQ_WRITE)
        begin
            // coordinates are 3 bits, so every write lands inside the 8x8 grid
            blocked_map[int'(it.cell_row) * GRID_COLS + int'(it.cell_col)] = it.cell_blocked;
            cell_writes++;
            return;
        end

        queries++;
        nr = usable_dim(rows_cfg, ROWS_CAP);
        nc = usable_dim(cols_cfg, COLS_CAP);
        if (it.src_row >= nr || it.src_col >= nc || it.dst_row >= nr || it.dst_col >= nc)
        begin
            expect_no_path();
            return;
        end

        src = int'(it.src_row) * GRID_COLS + int'(it.src_col);
        dst = int'(it.dst_row) * GRID_COLS + int'(it.dst_col);

        // breadth-first expansion: up, left, down, right; source occupancy ignored
        foreach (reached[i])
            reached[i] = 1'b0;
        reached[src]  = 1'b1;
        frontier[0]   = cell_idx_t'(src);
        head          = 0;
        frontier_tail = 1;
        while (head < frontier_tail)
        begin
            cur = int'(frontier[head]);
            if (cur == dst)
                break;
            head++;
            r = cur / GRID_COLS;
            c = cur % GRID_COLS;
            if (r > 0)
                discover(r - 1, c, DIR_UP);
            if (c > 0)
                discover(r, c - 1, DIR_LEFT);
            if (r + 1 < nr)
                discover(r + 1, c, DIR_DOWN);
            if (c + 1 < nc)
                discover(r, c + 1, DIR_RIGHT);
        end

        if (!reached[dst])
        begin
            expect_no_path();
            return;
        end

        // walk back along the discovering moves, destination first
        paths_found++;
        cur = dst;
        for (k = 0; k < CELLS; k++)
        begin
            r            = cur / GRID_COLS;
            c            = cur % GRID_COLS;
            res.found    = 1'b1;
            res.path_row = coord_t'(r);
            res.path_col = coord_t'(c);
            res.last     = (cur == src) || (k == CELLS - 1);
            expected_cells.push_back(res);
            if (res.last)
                break;
            case (came_from[cur])
                DIR_UP:   r = r + 1;
                DIR_LEFT: c = c + 1;
                DIR_DOWN: r = r - 1;
                default:  c = c - 1;
            endcase
            cur = (r * GRID_COLS + c) % CELLS;
        end
        if (k + 1 > longest_path)
            longest_path = k + 1;
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    // every accepted result against the oldest owed path cell
    always @(posedge clk)
    begin
        gbpf_out_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            results_seen++;
            if (expected_cells.size() == 0)
                report_mismatch("result with nothing pending", 32'(out_data), 32'd0);
            else
            begin
                want = expected_cells.pop_front();
                if (out_data.found !== want.found)
                    report_mismatch("found", 32'(out_data.found), 32'(want.found));
                if (out_data.path_row !== want.path_row)
                    report_mismatch("path_row", 32'(out_data.path_row), 32'(want.path_row));
                if (out_data.path_col !== want.path_col)
                    report_mismatch("path_col", 32'(out_data.path_col), 32'(want.path_col));
                if (out_data.last !== want.last)
                    report_mismatch("last", 32'(out_data.last), 32'(want.last));
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver side
    // ---------------------------------------------------------------

    // random stall, forced high while a hold-off is running
    always @(negedge clk)
        out_stall <= recv_hold || ($urandom_range(99) < recv_stall_pct);

    // long hold-off, counted here so the sender keeps going meanwhile
    initial
    begin
        forever
        begin
            @(holdoff_kick);
            recv_hold = 1'b1;
            repeat (HOLDOFF_CYCLES) @(negedge clk);
            recv_hold = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------

    task automatic set_pace(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    // offer one item after a random gap and hold it until the block takes it
    task automatic send_item(input gbpf_in_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        items_accepted++;
        predict_grid_item(it);
    endtask

    // every field random; callers overwrite the ones that matter
    function automatic gbpf_in_t noise_item();
        gbpf_in_t it;
        it.req_type     = 1'($urandom_range(1));
        it.cell_row     = coord_t'($urandom_range(7));
        it.cell_col     = coord_t'($urandom_range(7));
        it.cell_blocked = 1'($urandom_range(1));
        it.src_row      = coord_t'($urandom_range(7));
        it.src_col      = coord_t'($urandom_range(7));
        it.dst_row      = coord_t'($urandom_range(7));
        it.dst_col      = coord_t'($urandom_range(7));
        return it;
    endfunction

    task automatic send_cell_write(input int r, input int c, input logic blocked);
        gbpf_in_t it;
        it              = noise_item();
        it.req_type     = REQ_WRITE;
        it.cell_row     = coord_t'(r);
        it.cell_col     = coord_t'(c);
        it.cell_blocked = blocked;
        send_item(it);
    endtask

    task automatic send_query(input int sr, input int sc, input int dr, input int dc);
        gbpf_in_t it;
        it          = noise_item();
        it.req_type = REQ_QUERY;
        it.src_row  = coord_t'(sr);
        it.src_col  = coord_t'(sc);
        it.dst_row  = coord_t'(dr);
        it.dst_col  = coord_t'(dc);
        send_item(it);
    endtask

    // drop valid, let every owed cell arrive, then give a write time to land
    task automatic wait_all_results(input int settle);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // apb write of a dimension register followed by a readback
    task automatic set_dim_register(input logic idx, input dim_t value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {28'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (idx == REG_ROWS_IN_USE)
            rows_cfg = value;
        else
            cols_cfg = value;
        // back to setup with pwrite low for the read
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (prdata !== {28'd0, value})
            report_mismatch("register readback", prdata, {28'd0, value});
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_dims(input dim_t rows, input dim_t cols);
        wait_all_results(DRAIN_CYCLES);
        set_dim_register(REG_ROWS_IN_USE, rows);
        set_dim_register(REG_COLS_IN_USE, cols);
    endtask

    // register value for a random episode: mostly 1..8, some zero, some over range
    function automatic dim_t pick_dim();
        int roll;
        roll = $urandom_range(99);
        if (roll < 6)
            return 4'd0;
        if (roll < 18)
            return dim_t'($urandom_range(9, 15));
        return dim_t'($urandom_range(1, 8));
    endfunction

    function automatic coord_t coord_in(input int n);
        if (n == 0)
            return coord_t'($urandom_range(7));
        return coord_t'($urandom_range(n - 1));
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // empty 8x8 grid: trivial query and the long corner-to-corner ones
    task automatic test_open_grid_paths();
        set_pace(0, 0);
        send_query(0, 0, 0, 0);
        send_query(0, 0, 7, 7);
        send_query(7, 7, 0, 0);
        send_query(7, 0, 0, 7);
    endtask

    // boxed-in source, blocked ends, and clearing cells again
    task automatic test_walls_and_blocked_ends();
        send_cell_write(0, 1, 1'b1);
        send_cell_write(1, 0, 1'b1);
        send_query(0, 0, 5, 5);         // source has no open neighbor
        send_query(5, 5, 0, 0);         // destination walled in
        send_query(2, 2, 0, 1);         // blocked destination
        send_query(0, 1, 3, 3);         // blocked source still searches
        send_query(1, 0, 1, 0);         // blocked source equal to destination
        send_cell_write(7, 7, 1'b1);
        send_cell_write(0, 1, 1'b0);
        send_query(0, 0, 7, 6);         // detour around the remaining wall cell
        send_cell_write(7, 7, 1'b0);
        send_cell_write(1, 0, 1'b0);
    endtask

    // strips, zero size, clamped sizes and coordinates past the used area
    task automatic test_dimension_limits();
        set_dims(4'd1, 4'd8);
        send_query(0, 0, 0, 7);
        send_query(0, 0, 1, 0);         // destination row outside
        set_dims(4'd8, 4'd1);
        send_query(0, 0, 7, 0);
        send_query(0, 1, 0, 0);         // source column outside
        set_dims(4'd0, 4'd1);
        send_query(0, 0, 0, 0);         // zero rows fails everything
        set_dims(4'd15, 4'd9);
        send_query(7, 7, 0, 0);         // both clamp to eight
        set_dims(4'd3, 4'd5);
        send_query(2, 4, 0, 0);
        send_query(0, 0, 3, 0);
        set_dims(4'd8, 4'd8);
    endtask

    // receiver holds off while queries keep coming, so the input side stalls
    task automatic test_output_holdoff();
        int k;
        wait_all_results(DRAIN_CYCLES);
        set_pace(0, 0);
        -> holdoff_kick;
        for (k = 0; k < 12; k++)
            send_query($urandom_range(7), $urandom_range(7),
                       $urandom_range(7), $urandom_range(7));
        wait_all_results(DRAIN_CYCLES);
    endtask

    // episodes of random cell writes followed by queries inside the used area;
    // the dimensions change every few episodes, a few items are pure noise
    task automatic test_random_mazes(input int idle_pct, input int stall_pct,
                                     input int n_items);
        int       first, nr, nc, burst, k;
        gbpf_in_t it;
        set_pace(idle_pct, stall_pct);
        first = items_accepted;
        while (items_accepted - first < n_items)
        begin
            if ($urandom_range(2) == 0)
                set_dims(pick_dim(), pick_dim());
            nr = usable_dim(rows_cfg, ROWS_CAP);
            nc = usable_dim(cols_cfg, COLS_CAP);

            // roughly a third of the touched cells end up blocked
            burst = $urandom_range(2, 8);
            for (k = 0; k < burst; k++)
            begin
                it              = noise_item();
                it.req_type     = REQ_WRITE;
                it.cell_row     = coord_in(nr);
                it.cell_col     = coord_in(nc);
                it.cell_blocked = ($urandom_range(99) < 35);
                send_item(it);
            end

            burst = $urandom_range(1, 4);
            for (k = 0; k < burst; k++)
            begin
                it          = noise_item();
                it.req_type = REQ_QUERY;
                it.src_row  = coord_in(nr);
                it.src_col  = coord_in(nc);
                it.dst_row  = coord_in(nr);
                it.dst_col  = coord_in(nc);
                // occasionally let the destination fall anywhere
                if ($urandom_range(9) == 0)
                begin
                    it.dst_row = coord_t'($urandom_range(7));
                    it.dst_col = coord_t'($urandom_range(7));
                end
                send_item(it);
            end

            if ($urandom_range(4) == 0)
                send_item(noise_item());
        end
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_open_grid_paths();
        test_walls_and_blocked_ends();
        test_dimension_limits();
        test_output_holdoff();
        test_random_mazes(0, 0, 86);
        test_random_mazes(54, 0, 86);
        test_random_mazes(0, 54, 86);
        test_random_mazes(30, 30, 86);

        wait_all_results(FINAL_SETTLE);

        $display("covered %0d items: %0d cell writes, %0d queries, %0d result cells checked",
                 items_accepted, cell_writes, queries, results_seen);
        $display("%0d paths found (longest %0d cells), %0d failed searches, %0d mismatches",
                 paths_found, longest_path, no_path_items, mismatch_count);
        if (mismatch_count == 0)
            $display("grid_bfs_path_finder_core test passed");
        else
            $display("grid_bfs_path_finder_core test failed");
        $finish;
    end

endmodule
